// File: rtl/cesd_pkg.sv
// cesd_pkg: types and constants shared by the escape decoder modules
// no dependencies; compiled first
`default_nettype none

package cesd_pkg;

  // most bytes one input byte can produce (escape closed at end of string)
  localparam int MAX_OUT   = 4;
  localparam int OUT_IDX_W = 2;
  localparam int OUT_CNT_W = 3;

  // character codes the decoder tests against
  localparam logic [7:0] CH_BSL  = 8'h5C;  // backslash
  localparam logic [7:0] CH_X    = 8'h78;  // 'x'
  localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CH_NUL  = 8'h00;

  // bytes produced by one input byte, handed from decoder to serializer
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] chars;
    logic [OUT_CNT_W-1:0]    cnt;
    logic                    fin;
  } bundle_t;

endpackage

`default_nettype wire

// File: rtl/cesd_if.sv
// cesd_in_if / cesd_out_if: valid-ready channels of the escape decoder
// no dependencies
`default_nettype none

interface cesd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_final;

  modport source (output valid, output in_char, output in_final, input ready);
  modport sink (input valid, input in_char, input in_final, output ready);
endinterface

interface cesd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_final;

  modport source (output valid, output out_char, output out_final, input ready);
  modport sink (input valid, input out_char, input out_final, output ready);
endinterface

`default_nettype wire

// File: rtl/cesd_front.sv
// cesd_front: escape state tracker, turns each input byte into a bundle
// depends on cesd_pkg and cesd_in_if
`default_nettype none

module cesd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  cesd_in_if.sink               in_ch,
  input  wire logic             q_full,
  output logic                  push,
  output cesd_pkg::bundle_t     push_data
);
  import cesd_pkg::*;

  typedef enum logic [3:0] {
    ST_NONE = 4'b0001,  // nothing held
    ST_BSL  = 4'b0010,  // backslash held
    ST_LET  = 4'b0100,  // backslash and letter held
    ST_DIG  = 4'b1000   // backslash, letter and first digit held
  } esc_state_t;

  esc_state_t st_r, st_nxt;
  logic [7:0] letter_r, letter_nxt;
  logic [7:0] digit_r, digit_nxt;
  bundle_t    bnd;
  logic       accept;

  // append one byte to a bundle
  function automatic bundle_t add_byte(bundle_t b, logic [7:0] ch);
    bundle_t r;
    r = b;
    if (r.cnt < OUT_CNT_W'(MAX_OUT)) begin
      r.chars[r.cnt[OUT_IDX_W-1:0]] = ch;
      r.cnt = r.cnt + OUT_CNT_W'(1);
    end
    return r;
  endfunction

  // single-letter escapes, returns {hit, value}
  function automatic logic [8:0] simple_esc(logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h61:   r = {1'b1, 8'h07};  // a
      8'h62:   r = {1'b1, 8'h08};  // b
      8'h66:   r = {1'b1, 8'h0C};  // f
      8'h6E:   r = {1'b1, 8'h0A};  // n
      8'h72:   r = {1'b1, 8'h0D};  // r
      8'h74:   r = {1'b1, 8'h09};  // t
      8'h76:   r = {1'b1, 8'h0B};  // v
      8'h5C:   r = {1'b1, 8'h5C};  // backslash
      8'h3F:   r = {1'b1, 8'h3F};  // question mark
      8'h27:   r = {1'b1, 8'h27};  // single quote
      8'h22:   r = {1'b1, 8'h22};  // double quote
      default: r = {1'b0, 8'h00};
    endcase
    return r;
  endfunction

  function automatic logic is_dec(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_dec(c) || ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  // nibble of a valid hex digit
  function automatic logic [3:0] hex_nib(logic [7:0] c);
    return is_dec(c) ? c[3:0] : (c[3:0] + 4'd9);
  endfunction

  function automatic logic digit_ok(logic [7:0] let_c, logic [7:0] c);
    return (let_c == CH_X) ? is_hex(c) : is_dec(c);
  endfunction

  // value of a complete numeric escape, octal-style weights wrap at 8 bits
  function automatic logic [7:0] num_val(logic [7:0] let_c, logic [7:0] d2, logic [7:0] c);
    logic [7:0] l8;
    logic [7:0] m8;
    logic [7:0] c8;
    l8 = let_c - CH_ZERO;
    m8 = d2 - CH_ZERO;
    c8 = c - CH_ZERO;
    if (let_c == CH_X) begin
      return {hex_nib(d2), hex_nib(c)};
    end
    return {l8[1:0], 6'b0} + {m8[4:0], 3'b0} + c8;
  endfunction

  // escape that cannot complete: NUL for a lone \0, else backslash and letter
  function automatic bundle_t fail_esc(bundle_t b, logic [7:0] let_c);
    bundle_t r;
    r = b;
    if (let_c == CH_ZERO) begin
      r = add_byte(r, CH_NUL);
    end else begin
      r = add_byte(r, CH_BSL);
      r = add_byte(r, let_c);
    end
    return r;
  endfunction

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // decode one byte, then close any open escape at end of string
  always_comb begin
    logic [7:0] c;
    logic [8:0] se;
    c          = in_ch.in_char;
    se         = simple_esc(c);
    st_nxt     = st_r;
    letter_nxt = letter_r;
    digit_nxt  = digit_r;
    bnd        = '0;
    case (st_r)
      ST_NONE: begin
        if (c == CH_BSL) st_nxt = ST_BSL;
        else bnd = add_byte(bnd, c);
      end
      ST_BSL: begin
        letter_nxt = c;
        if (se[8]) begin
          bnd    = add_byte(bnd, se[7:0]);
          st_nxt = ST_NONE;
        end else if ((c == CH_X) || is_dec(c)) begin
          st_nxt = ST_LET;
        end else begin
          bnd    = add_byte(bnd, CH_BSL);
          bnd    = add_byte(bnd, c);
          st_nxt = ST_NONE;
        end
      end
      ST_LET: begin
        if (digit_ok(letter_r, c)) begin
          digit_nxt = c;
          st_nxt    = ST_DIG;
        end else begin
          bnd = fail_esc(bnd, letter_r);
          if (c == CH_BSL) begin
            st_nxt = ST_BSL;
          end else begin
            st_nxt = ST_NONE;
            bnd    = add_byte(bnd, c);
          end
        end
      end
      ST_DIG: begin
        if (digit_ok(letter_r, c)) begin
          bnd    = add_byte(bnd, num_val(letter_r, digit_r, c));
          st_nxt = ST_NONE;
        end else begin
          bnd = fail_esc(bnd, letter_r);
          bnd = add_byte(bnd, digit_r);
          if (c == CH_BSL) begin
            st_nxt = ST_BSL;
          end else begin
            st_nxt = ST_NONE;
            bnd    = add_byte(bnd, c);
          end
        end
      end
      default: st_nxt = ST_NONE;
    endcase
    // end of string flushes whatever is still held
    if (in_ch.in_final) begin
      case (st_nxt)
        ST_BSL: bnd = add_byte(bnd, CH_BSL);
        ST_LET: bnd = fail_esc(bnd, letter_nxt);
        ST_DIG: begin
          bnd = fail_esc(bnd, letter_nxt);
          bnd = add_byte(bnd, digit_nxt);
        end
        default: ;
      endcase
      st_nxt  = ST_NONE;
      bnd.fin = 1'b1;
    end
  end

  assign push      = accept && (bnd.cnt != '0);
  assign push_data = bnd;

  // escape state, advanced on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_NONE;
      letter_r <= '0;
      digit_r  <= '0;
    end else if (accept) begin
      st_r     <= st_nxt;
      letter_r <= letter_nxt;
      digit_r  <= digit_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/cesd_fifo.sv
// cesd_fifo: small bundle queue between decoder and serializer
// depends on cesd_pkg
`default_nettype none

module cesd_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire cesd_pkg::bundle_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output cesd_pkg::bundle_t      head
);
  import cesd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem[rd_ptr_r];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: rtl/cesd_back.sv
// cesd_back: serializer, sends the bytes of each bundle one per transfer
// depends on cesd_pkg and cesd_out_if
`default_nettype none

module cesd_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              head_valid,
  input  wire cesd_pkg::bundle_t head,
  output logic                   pop,
  cesd_out_if.source             out_ch
);
  import cesd_pkg::*;

  logic [OUT_IDX_W-1:0] idx_r;
  logic [7:0]           char_r;
  logic                 final_r;
  logic                 valid_r;
  logic                 load;
  logic                 last_byte;

  assign load      = head_valid && (!valid_r || out_ch.ready);
  assign last_byte = ({1'b0, idx_r} == (head.cnt - OUT_CNT_W'(1)));
  assign pop       = load && last_byte;

  assign out_ch.valid     = valid_r;
  assign out_ch.out_char  = char_r;
  assign out_ch.out_final = final_r;

  // output register, payload
  always_ff @(posedge clk) begin
    if (load) begin
      char_r  <= head.chars[idx_r];
      final_r <= head.fin && last_byte;
    end
  end

  // output valid and byte index within the head bundle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) valid_r <= 1'b1;
      else if (out_ch.ready) valid_r <= 1'b0;
      if (load) idx_r <= last_byte ? '0 : idx_r + OUT_IDX_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: rtl/c_escape_sequence_decoder_unit.sv
// Decodes C backslash escapes in a byte stream: the eleven single-letter
// escapes, \x with two hex digits, and a backslash with three decimal digits
// (first*64 + second*8 + third, wrapped to 8 bits); a lone \0 gives NUL, and
// an unknown or unfinished escape is passed through as literal text. An input
// transfer is taken every cycle while the bundle queue has room; one input
// byte yields zero to four output bytes, and the output serializer sends one
// byte per cycle while the receiver is ready, so the sustained rate is one
// input byte per cycle when each yields at most one output byte; an input that
// yields more holds the output for each of its bytes (the QUEUE_DEPTH-entry
// queue absorbs such bursts). Bytes pass the queue, then the output register.
// Depends on cesd_pkg, cesd_if, cesd_front, cesd_fifo and cesd_back.
`default_nettype none

module c_escape_sequence_decoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cesd_in_if.sink     in_ch,
  cesd_out_if.source  out_ch
);
  import cesd_pkg::*;

  logic    q_full;
  logic    q_push;
  bundle_t q_push_data;
  logic    q_pop;
  logic    q_head_valid;
  bundle_t q_head;

  // decoder: escape state and per-byte bundle
  cesd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  // queue between decoder and serializer
  cesd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // serializer into the output register
  cesd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// File: bench/cesd_checker.sv
// cesd_checker: watches both channels of the escape decoder, predicts the
// decoded bytes of every input transfer and compares each output transfer
// depends on cesd_pkg and cesd_if

module cesd_checker
  import cesd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  cesd_in_if   in_mon,
  cesd_out_if  out_mon,
  output int   mismatches,
  output int   awaiting
);

  // how much of an open escape is being held
  typedef enum logic [1:0] {
    HELD_NONE,
    HELD_BSL,
    HELD_LETTER,
    HELD_DIGIT
  } held_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } dec_byte_t;

  held_t      held;
  logic [7:0] esc_ltr;
  logic [7:0] dig1;
  dec_byte_t  step_q[$];
  dec_byte_t  decoded_q[$];
  int         errs;

  function automatic bit is_dec(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  // single-letter escapes, -1 when the letter is not one of them
  function automatic int escape_map(input logic [7:0] c);
    case (c)
      "a":  return 8'h07;
      "b":  return 8'h08;
      "f":  return 8'h0C;
      "n":  return 8'h0A;
      "r":  return 8'h0D;
      "t":  return 8'h09;
      "v":  return 8'h0B;
      "\\": return CH_BSL;
      "?":  return "?";
      "'":  return "'";
      "\"": return "\"";
      default: return -1;
    endcase
  endfunction

  function automatic bit digit_fits(input logic [7:0] c);
    if (esc_ltr == CH_X) return hex_value(c) >= 0;
    return is_dec(c);
  endfunction

  task automatic put_byte(input logic [7:0] c);
    if (step_q.size() < MAX_OUT) step_q.push_back('{ch: c, fin: 1'b0});
  endtask

  task automatic start_fresh(input logic [7:0] c);
    if (c == CH_BSL) begin
      held = HELD_BSL;
    end else begin
      held = HELD_NONE;
      put_byte(c);
    end
  endtask

  // numeric escape that cannot complete: \0 gives NUL, else literal text
  task automatic abandon_escape();
    if (esc_ltr == CH_ZERO) begin
      put_byte(CH_NUL);
    end else begin
      put_byte(CH_BSL);
      put_byte(esc_ltr);
    end
    held = HELD_NONE;
  endtask

  task automatic decode_byte(input logic [7:0] c);
    int m;
    int v;
    case (held)
      HELD_NONE: start_fresh(c);
      HELD_BSL: begin
        esc_ltr = c;
        m = escape_map(c);
        if (m >= 0) begin
          put_byte(m[7:0]);
          held = HELD_NONE;
        end else if (c == CH_X || is_dec(c)) begin
          held = HELD_LETTER;
        end else begin
          // unknown escape passes through
          put_byte(CH_BSL);
          put_byte(c);
          held = HELD_NONE;
        end
      end
      HELD_LETTER: begin
        if (digit_fits(c)) begin
          dig1 = c;
          held = HELD_DIGIT;
        end else begin
          abandon_escape();
          start_fresh(c);
        end
      end
      default: begin
        if (digit_fits(c)) begin
          if (esc_ltr == CH_X) begin
            v = hex_value(dig1) * 16 + hex_value(c);
          end else begin
            v = (int'(esc_ltr) - int'(CH_ZERO)) * 64 + (int'(dig1) - int'(CH_ZERO)) * 8
              + int'(c) - int'(CH_ZERO);
          end
          put_byte(v[7:0]);
          held = HELD_NONE;
        end else begin
          abandon_escape();
          put_byte(dig1);
          start_fresh(c);
        end
      end
    endcase
  endtask

  // end of string closes whatever escape is open
  task automatic close_string();
    case (held)
      HELD_BSL:    put_byte(CH_BSL);
      HELD_LETTER: abandon_escape();
      HELD_DIGIT: begin
        abandon_escape();
        put_byte(dig1);
      end
      default: ;
    endcase
    held = HELD_NONE;
  endtask

  task automatic predict(input logic [7:0] c, input logic fin);
    step_q.delete();
    decode_byte(c);
    if (fin) begin
      close_string();
      if (step_q.size() > 0) step_q[step_q.size()-1].fin = 1'b1;
    end
    foreach (step_q[i]) decoded_q.push_back(step_q[i]);
  endtask

  // predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    dec_byte_t want;
    if (!rst_n) begin
      held = HELD_NONE;
      esc_ltr = 8'h00;
      dig1 = 8'h00;
      decoded_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) predict(in_mon.in_char, in_mon.in_final);
      if (out_mon.valid && out_mon.ready) begin
        if (decoded_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected output byte %02h final %0b", $time,
                   out_mon.out_char, out_mon.out_final);
        end else begin
          want = decoded_q.pop_front();
          if (want.ch !== out_mon.out_char) begin
            errs++;
            $display("%0t: out_char mismatch: expected %02h, actual %02h", $time,
                     want.ch, out_mon.out_char);
          end
          if (want.fin !== out_mon.out_final) begin
            errs++;
            $display("%0t: out_final mismatch: expected %0b, actual %0b", $time,
                     want.fin, out_mon.out_final);
          end
        end
      end
    end
    mismatches <= errs;
    awaiting <= decoded_q.size();
  end

endmodule

// File: bench/tb_c_escape_sequence_decoder_unit.sv
// tb_c_escape_sequence_decoder_unit: drives escape-laden text into the decoder
// under random idling and long output stalls, and reports the verdict
// depends on cesd_pkg, cesd_if, the decoder RTL and cesd_checker

module tb_c_escape_sequence_decoder_unit;
  import cesd_pkg::*;

  logic  clk = 1'b0;
  logic  rst_n;
  int    tx_idle_pct;
  int    rx_idle_pct;
  int    hold_req;
  int    hold_ack;
  int    hold_left;
  int    fail_count;
  int    open_count;
  string esc_letters = "abfnrtv\\?'\"";
  string hex_digits = "0123456789ABCDEFabcdef";

  cesd_in_if  in_if ();
  cesd_out_if out_if ();

  c_escape_sequence_decoder_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  cesd_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .mismatches (fail_count),
    .awaiting   (open_count)
  );

  always #5 clk = ~clk;

  // receiver: random back-pressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= 80;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // one input transfer, with random idle cycles in front
  task automatic send_byte(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.in_char <= c;
    in_if.in_final <= fin;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic send_text(input string s, input logic fin_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin_last && (i == s.len() - 1));
  endtask

  // mostly well-formed escapes with random content, some plain text and noise
  task automatic run_random(input int n_items);
    int         sent;
    int         kind;
    logic [7:0] rnd;
    logic [7:0] tok[$];
    sent = 0;
    while (sent < n_items) begin
      tok.delete();
      kind = $urandom_range(99);
      rnd = 8'($urandom_range(255, 1));
      if (kind < 35) begin
        tok.push_back(rnd);
      end else if (kind < 55) begin
        tok.push_back(CH_BSL);
        tok.push_back(esc_letters[$urandom_range(10)]);
      end else if (kind < 70) begin
        tok.push_back(CH_BSL);
        tok.push_back(CH_X);
        tok.push_back(hex_digits[$urandom_range(21)]);
        tok.push_back(hex_digits[$urandom_range(21)]);
      end else if (kind < 85) begin
        tok.push_back(CH_BSL);
        repeat (3) tok.push_back(CH_ZERO + 8'($urandom_range(9)));
      end else begin
        // broken escape: cut short by an arbitrary byte
        tok.push_back(CH_BSL);
        case ($urandom_range(4))
          1: tok.push_back(CH_X);
          2: tok.push_back(CH_ZERO + 8'($urandom_range(9)));
          3: repeat (2) tok.push_back(CH_ZERO + 8'($urandom_range(9)));
          4: begin
            tok.push_back(CH_X);
            tok.push_back(hex_digits[$urandom_range(21)]);
          end
          default: ;
        endcase
        tok.push_back(rnd);
      end
      foreach (tok[i]) begin
        send_byte(tok[i], $urandom_range(29) == 0);
        sent++;
      end
    end
  endtask

  // run limit
  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_char = 8'h00;
    in_if.in_final = 1'b0;
    out_if.ready = 1'b0;
    tx_idle_pct = 23;
    rx_idle_pct = 49;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, each escape form, failures, end of string
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("\\n", 1'b0);
    send_text("\\xfA", 1'b0);
    send_text("\\377", 1'b0);
    send_text("\\999", 1'b0);
    send_text("\\0z", 1'b0);
    send_text("\\q", 1'b0);
    send_text("\\xg", 1'b0);
    send_text("\\12", 1'b1);
    send_text("\\", 1'b1);

    hold_req <= hold_req + 1;
    run_random(145);

    tx_idle_pct = 49;
    rx_idle_pct <= 23;
    run_random(145);

    // no idling, with a long output stall so the input backs up
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_req <= hold_req + 1;
    run_random(145);

    in_if.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
